// ===== src/sparse_set_inclusion_matcher_core_defines.svh =====
// Assertion macros shared by the matcher RTL.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef SPARSE_SET_INCLUSION_MATCHER_CORE_DEFINES_SVH
`define SPARSE_SET_INCLUSION_MATCHER_CORE_DEFINES_SVH

// same-cycle implication
`define SSIM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssim assertion failed");

// next-cycle implication
`define SSIM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssim assertion failed");

`endif

// ===== src/ssim_pkg.sv =====
// Shared types and constants for the sparse set inclusion matcher.
// No dependencies.
package ssim_pkg;

  localparam int ATTR_W  = 8;
  localparam int GRADE_W = 8;
  localparam int IDX_W   = 6;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_GRADED = 2'd0,
    MODE_BIN    = 2'd1,
    MODE_EQ     = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT_SET,
    ST_LOAD_END,
    ST_ISSUE,
    ST_CHECK,
    ST_HIT,
    ST_FAIL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic init;
    logic begin_set;
    logic step_hit;
    logic step_miss;
    logic record;
    logic advance;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic close_query;
    logic set_done;
    logic len_ok;
    logic qlen_zero;
    logic eq_mode;
    logic s_at_end;
    logic attr_eq;
    logic hit;
    logic q_last;
    logic can_emit;
    logic pend_v;
  } dp_status_t;

endpackage

// ===== src/ssim_ctrl.sv =====
// Matcher controller: state machine sequencing item intake and the store walk.
// Depends on ssim_pkg.
module ssim_ctrl import ssim_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd,
  output logic       in_ready
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (st.in_valid && st.close_query) state_nxt = ST_NEXT_SET;
      end
      ST_NEXT_SET: begin
        state_nxt = st.set_done ? ST_FINISH : ST_LOAD_END;
      end
      ST_LOAD_END: begin
        if (st.eq_mode) begin
          if (!st.len_ok)        state_nxt = ST_FAIL;
          else if (st.qlen_zero) state_nxt = ST_HIT;
          else                   state_nxt = ST_ISSUE;
        end else begin
          state_nxt = st.qlen_zero ? ST_FAIL : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_nxt = st.s_at_end ? ST_FAIL : ST_CHECK;
      end
      ST_CHECK: begin
        if (st.hit)             state_nxt = st.q_last ? ST_HIT : ST_ISSUE;
        else if (st.eq_mode)    state_nxt = ST_FAIL;
        else                    state_nxt = ST_ISSUE;
      end
      ST_HIT: begin
        if (st.can_emit || !st.pend_v) state_nxt = ST_NEXT_SET;
      end
      ST_FAIL: begin
        state_nxt = ST_NEXT_SET;
      end
      ST_FINISH: begin
        if (st.can_emit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = st.in_valid;
        cmd.init   = st.in_valid && st.close_query;
      end
      ST_LOAD_END: cmd.begin_set = 1'b1;
      ST_CHECK: begin
        cmd.step_hit  = st.hit;
        cmd.step_miss = !st.hit && !st.eq_mode;
      end
      ST_HIT:    cmd.record  = st.can_emit || !st.pend_v;
      ST_FAIL:   cmd.advance = 1'b1;
      ST_FINISH: cmd.finish  = st.can_emit;
      default: ;
    endcase
  end

endmodule

// ===== src/ssim_datapath.sv =====
// Matcher datapath: entry store, set end table, query buffer, walk counters
// and the result register. Depends on ssim_pkg and the assertion macro header.
`include "sparse_set_inclusion_matcher_core_defines.svh"
module ssim_datapath import ssim_pkg::*; #(
  parameter int MAX_SETS       = 64,
  parameter int MAX_ENTRIES    = 1024,
  parameter int MAX_ATTRIBUTES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         st,
  input  logic [1:0]         cfg_wr_data,
  input  logic               cfg_wr_en,
  input  logic               in_valid,
  input  logic [1:0]         in_command,
  input  logic [ATTR_W-1:0]  in_attribute,
  input  logic [GRADE_W-1:0] in_grade,
  input  logic               in_no_entry,
  input  logic               in_last_entry,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   out_match_index,
  output logic               out_match_found,
  output logic               out_last_match,
  output logic               out_overflow
);

  localparam int SW  = $clog2(MAX_SETS + 1);
  localparam int KW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int EW  = $clog2(MAX_ENTRIES + 1);
  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int QW  = $clog2(MAX_ATTRIBUTES + 1);
  localparam int QAW = $clog2(MAX_ATTRIBUTES);
  localparam int LW  = (EW > QW) ? EW : QW;

  logic [ATTR_W-1:0]  st_attr_mem [MAX_ENTRIES];
  logic [GRADE_W-1:0] st_grade_mem [MAX_ENTRIES];
  logic [EW-1:0]      end_mem [MAX_SETS];
  logic [ATTR_W-1:0]  q_attr_mem [MAX_ATTRIBUTES];
  logic [GRADE_W-1:0] q_grade_mem [MAX_ATTRIBUTES];

  logic [ATTR_W-1:0]  st_attr_rd, q_attr_rd;
  logic [GRADE_W-1:0] st_grade_rd, q_grade_rd;
  logic [EW-1:0]      end_rd;

  logic [1:0]       mode_r;
  logic [SW-1:0]    set_cnt_r, set_cnt_nxt;
  logic [EW-1:0]    fill_r, fill_nxt;
  logic [QW-1:0]    qlen_r, qlen_nxt;
  logic             ovf_r, ovf_nxt;
  logic [SW-1:0]    k_r;
  logic [EW-1:0]    start_r, end_r, s_r;
  logic [QW-1:0]    q_r;
  logic             pend_v_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_found_r, out_last_r, out_ovf_r;

  logic is_load, is_query, is_clear, store_wr, end_wr, query_wr;
  logic eq_mode, bin_mode, can_emit;

  assign is_load  = cmd.accept && (in_command == CMD_LOAD);
  assign is_query = cmd.accept && (in_command == CMD_QUERY);
  assign is_clear = cmd.accept && (in_command == CMD_CLEAR);
  assign store_wr = is_load && !in_no_entry && (set_cnt_r < SW'(MAX_SETS))
                    && (fill_r < EW'(MAX_ENTRIES));
  assign end_wr   = is_load && in_last_entry && (set_cnt_r < SW'(MAX_SETS));
  assign query_wr = is_query && !in_no_entry && (qlen_r < QW'(MAX_ATTRIBUTES));

  assign eq_mode  = (mode_r == MODE_EQ);
  assign bin_mode = (mode_r == MODE_BIN);
  assign can_emit = !out_valid_r || out_ready;

  always_comb begin
    set_cnt_nxt = set_cnt_r;
    fill_nxt    = fill_r;
    qlen_nxt    = qlen_r;
    ovf_nxt     = ovf_r;
    if (is_clear) begin
      set_cnt_nxt = '0;
      fill_nxt    = '0;
      qlen_nxt    = '0;
    end
    if (is_load) begin
      if (store_wr) fill_nxt = fill_r + EW'(1);
      else if (!in_no_entry) ovf_nxt = 1'b1;
      if (end_wr) set_cnt_nxt = set_cnt_r + SW'(1);
      else if (in_last_entry) ovf_nxt = 1'b1;
    end
    if (is_query) begin
      if (query_wr) qlen_nxt = qlen_r + QW'(1);
      else if (!in_no_entry) ovf_nxt = 1'b1;
    end
    if (cmd.finish) qlen_nxt = '0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if ((cmd.record && pend_v_r) || cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      st_attr_mem[fill_r[AW-1:0]]  <= in_attribute;
      st_grade_mem[fill_r[AW-1:0]] <= in_grade;
    end
    if (end_wr) end_mem[set_cnt_r[KW-1:0]] <= fill_nxt;
    if (query_wr) begin
      q_attr_mem[qlen_r[QAW-1:0]]  <= in_attribute;
      q_grade_mem[qlen_r[QAW-1:0]] <= in_grade;
    end
    st_attr_rd  <= st_attr_mem[s_r[AW-1:0]];
    st_grade_rd <= st_grade_mem[s_r[AW-1:0]];
    q_attr_rd   <= q_attr_mem[q_r[QAW-1:0]];
    q_grade_rd  <= q_grade_mem[q_r[QAW-1:0]];
    end_rd      <= end_mem[k_r[KW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_GRADED;
      set_cnt_r   <= '0;
      fill_r      <= '0;
      qlen_r      <= '0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      start_r     <= '0;
      end_r       <= '0;
      s_r         <= '0;
      q_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      set_cnt_r   <= set_cnt_nxt;
      fill_r      <= fill_nxt;
      qlen_r      <= qlen_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.init) begin
        k_r      <= '0;
        start_r  <= '0;
        pend_v_r <= 1'b0;
      end
      if (cmd.begin_set) begin
        end_r <= end_rd;
        s_r   <= start_r;
        q_r   <= '0;
      end
      if (cmd.step_hit) begin
        q_r <= q_r + QW'(1);
        s_r <= eq_mode ? s_r + EW'(1) : start_r;
      end
      if (cmd.step_miss) s_r <= s_r + EW'(1);
      if (cmd.record || cmd.advance) begin
        k_r     <= k_r + SW'(1);
        start_r <= end_r;
      end
      if (cmd.record) pend_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.record) begin
      pend_idx_r <= IDX_W'(k_r);
      if (pend_v_r) begin
        out_idx_r   <= pend_idx_r;
        out_found_r <= 1'b1;
        out_last_r  <= 1'b0;
        out_ovf_r   <= ovf_r;
      end
    end
    if (cmd.finish) begin
      out_idx_r   <= pend_v_r ? pend_idx_r : '0;
      out_found_r <= pend_v_r;
      out_last_r  <= 1'b1;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_index = out_idx_r;
  assign out_match_found = out_found_r;
  assign out_last_match  = out_last_r;
  assign out_overflow    = out_ovf_r;

  always_comb begin
    st             = '0;
    st.in_valid    = in_valid;
    st.close_query = (in_command == CMD_QUERY) && in_last_entry;
    st.set_done    = (k_r == set_cnt_r);
    st.len_ok      = (LW'(end_rd - start_r) == LW'(qlen_r));
    st.qlen_zero   = (qlen_r == '0);
    st.eq_mode     = eq_mode;
    st.s_at_end    = (s_r == end_r);
    st.attr_eq     = (st_attr_rd == q_attr_rd);
    st.hit         = st.attr_eq && (eq_mode || bin_mode || (st_grade_rd >= q_grade_rd));
    st.q_last      = ((q_r + QW'(1)) == qlen_r);
    st.can_emit    = can_emit;
    st.pend_v      = pend_v_r;
  end

  `SSIM_ASSERT_IMPL(a_fill_cap, 1'b1, fill_r <= EW'(MAX_ENTRIES))
  `SSIM_ASSERT_IMPL(a_set_cap, 1'b1, set_cnt_r <= SW'(MAX_SETS))
  `SSIM_ASSERT_IMPL(a_emit_room, (cmd.finish || (cmd.record && pend_v_r)), can_emit)
  `SSIM_ASSERT_NEXT(a_finish_clears, cmd.finish, (qlen_r == '0) && out_valid_r)

endmodule

// ===== src/sparse_set_inclusion_matcher_core.sv =====
// Sparse fuzzy set matcher: load items and query entries are taken only while idle.
// The item closing a query walks every stored set in load order through single-port
// stores: per set, the end is loaded, then compares issue and check until the set
// hits or fails, or a scan runs off the set end (equality: one compare per query
// entry; inclusion: up to one per stored entry per query entry); a finish closes it.
// A match is held in a pending register until the next match or the finish; the walk
// stalls at either while the result register holds an item that is not taken.
module sparse_set_inclusion_matcher_core import ssim_pkg::*; #(
  parameter int MAX_SETS       = 64,
  parameter int MAX_ENTRIES    = 1024,
  parameter int MAX_ATTRIBUTES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [ATTR_W-1:0]  in_attribute,
  input  logic [GRADE_W-1:0] in_grade,
  input  logic               in_no_entry,
  input  logic               in_last_entry,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   out_match_index,
  output logic               out_match_found,
  output logic               out_last_match,
  output logic               out_overflow
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  ssim_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .st       (st),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  ssim_datapath #(
    .MAX_SETS       (MAX_SETS),
    .MAX_ENTRIES    (MAX_ENTRIES),
    .MAX_ATTRIBUTES (MAX_ATTRIBUTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg_wr_data     (cfg_wr_data),
    .cfg_wr_en       (cfg_wr_en),
    .in_valid        (in_valid),
    .in_command      (in_command),
    .in_attribute    (in_attribute),
    .in_grade        (in_grade),
    .in_no_entry     (in_no_entry),
    .in_last_entry   (in_last_entry),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_index (out_match_index),
    .out_match_found (out_match_found),
    .out_last_match  (out_last_match),
    .out_overflow    (out_overflow)
  );

endmodule
